### hdl/lcdsc_pkg.sv
// shared types, constants and helpers for the lcd scan capture decoder
`timescale 1ns / 1ps

package lcdsc_pkg;

   // bit positions in a gpio sample word
   localparam int PCLK_BIT  = 4;
   localparam int LCLK_BIT  = 6;
   localparam int RED_LSB   = 7;
   localparam int GREEN_LSB = 16;
   localparam int BLUE_LSB  = 22;
   localparam int CH_WIDTH  = 6;

   // field widths
   localparam int SAMPLE_W = 32;
   localparam int COL_W    = 9;
   localparam int LINE_W   = 10;
   localparam int COLOR_W  = 24;

   // register reset values and defaults
   localparam logic [COL_W-1:0]  ACTIVE_START_RST    = 9'd28;
   localparam logic [COL_W-1:0]  ACTIVE_END_RST      = 9'd284;
   localparam logic [LINE_W-1:0] LINES_PER_FRAME_RST = 10'd192;
   localparam int                PIXEL_LIMIT_DEF     = 350;

   // csr port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = LINE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_START    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_END      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINES_PER_FRAME = 2'd2;

   // result kinds
   localparam logic KIND_PIXEL    = 1'b0;
   localparam logic KIND_LINE_END = 1'b1;

   // result queue depth
   localparam int RSP_DEPTH = 4;

   // stream widths
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;

   typedef struct packed {
      logic                kind;
      logic [LINE_W-1:0]   line;
      logic [COL_W-1:0]    column;
      logic [COLOR_W-1:0]  color;
      logic                copy_previous;
      logic                frame_done;
      logic                last;
   } rsp_item_type;

   // up to two results produced by one decoded sample
   typedef struct packed {
      logic         v0;
      logic         v1;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

   // expand the three 6-bit channels into 8-bit-per-channel color
   function automatic logic [COLOR_W-1:0] color_of(input logic [SAMPLE_W-1:0] s);
      color_of = {s[RED_LSB +: CH_WIDTH], 2'b00,
                  s[GREEN_LSB +: CH_WIDTH], 2'b00,
                  s[BLUE_LSB +: CH_WIDTH], 2'b00};
   endfunction

endpackage

### hdl/lcdsc_core.sv
// scan state, config registers and per-sample decode logic
`timescale 1ns / 1ps

module lcdsc_core #(
   parameter int PIXEL_LIMIT = lcdsc_pkg::PIXEL_LIMIT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [lcdsc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lcdsc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                   step,
   input  logic [lcdsc_pkg::SAMPLE_W-1:0]         sample,
   input  logic                                   block_break,
   input  logic                                   frame_start,
   output lcdsc_pkg::rsp_push_type                push
);
   import lcdsc_pkg::*;

   localparam logic [COL_W-1:0]  PIX_MAX  = COL_W'(PIXEL_LIMIT);
   localparam logic [LINE_W-1:0] LINE_MAX = '1;

   logic [COL_W-1:0]  active_start_ff;
   logic [COL_W-1:0]  active_end_ff;
   logic [LINE_W-1:0] lines_per_frame_ff;

   logic              scan_active_ff, scan_active_in;
   logic [1:0]        prev_clocks_ff, prev_clocks_in;
   logic [COL_W-1:0]  pixel_count_ff, pixel_count_in;
   logic [LINE_W-1:0] line_count_ff, line_count_in;
   logic              line_dirty_ff, line_dirty_in;

   logic [1:0]        cur;
   logic              pclk_edge;
   logic              lclk_rise;
   logic              frame_over;
   logic              live;
   logic              in_window;
   logic              pix_emit;
   logic              line_emit;
   logic [LINE_W-1:0] line_inc;
   rsp_item_type      pix_item;
   rsp_item_type      end_item;

   // config register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         active_start_ff    <= ACTIVE_START_RST;
         active_end_ff      <= ACTIVE_END_RST;
         lines_per_frame_ff <= LINES_PER_FRAME_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACTIVE_START:    active_start_ff    <= csr_wdata[COL_W-1:0];
            CSR_ACTIVE_END:      active_end_ff      <= csr_wdata[COL_W-1:0];
            CSR_LINES_PER_FRAME: lines_per_frame_ff <= csr_wdata[LINE_W-1:0];
            default: ;
         endcase
      end
   end

   // edge detection against the previous clock levels
   assign cur        = {sample[LCLK_BIT], sample[PCLK_BIT]};
   assign pclk_edge  = cur[0] ^ prev_clocks_ff[0];
   assign lclk_rise  = cur[1] & ~prev_clocks_ff[1];
   assign frame_over = line_count_ff >= lines_per_frame_ff;
   assign live       = ~frame_start & ~frame_over & ~block_break & scan_active_ff;
   assign in_window  = (pixel_count_ff >= active_start_ff) &&
                       (pixel_count_ff < active_end_ff);
   assign pix_emit   = live & pclk_edge & ~line_dirty_ff & in_window;
   assign line_emit  = live & lclk_rise;
   assign line_inc   = (line_count_ff == LINE_MAX) ? line_count_ff
                                                    : line_count_ff + 1'b1;

   // next scan state
   always_comb begin
      scan_active_in = scan_active_ff;
      prev_clocks_in = prev_clocks_ff;
      pixel_count_in = pixel_count_ff;
      line_count_in  = line_count_ff;
      line_dirty_in  = line_dirty_ff;
      if (frame_start) begin
         scan_active_in = 1'b0;
         pixel_count_in = '0;
         line_count_in  = '0;
         line_dirty_in  = 1'b0;
         prev_clocks_in = cur;
      end else if (!frame_over) begin
         prev_clocks_in = cur;
         if (block_break) begin
            if (scan_active_ff) line_dirty_in = 1'b1;
         end else if (!scan_active_ff) begin
            if (lclk_rise) begin
               pixel_count_in = '0;
               scan_active_in = 1'b1;
               line_dirty_in  = 1'b0;
            end
         end else begin
            if (pclk_edge && !line_dirty_ff && pixel_count_ff < PIX_MAX)
               pixel_count_in = pixel_count_ff + 1'b1;
            if (lclk_rise) begin
               line_count_in  = line_inc;
               pixel_count_in = '0;
               line_dirty_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_active_ff <= 1'b0;
         prev_clocks_ff <= '0;
         pixel_count_ff <= '0;
         line_count_ff  <= '0;
         line_dirty_ff  <= 1'b0;
      end else if (step) begin
         scan_active_ff <= scan_active_in;
         prev_clocks_ff <= prev_clocks_in;
         pixel_count_ff <= pixel_count_in;
         line_count_ff  <= line_count_in;
         line_dirty_ff  <= line_dirty_in;
      end
   end

   // result items
   always_comb begin
      pix_item               = '0;
      pix_item.kind          = KIND_PIXEL;
      pix_item.line          = line_count_ff;
      pix_item.column        = pixel_count_ff - active_start_ff;
      pix_item.color         = color_of(sample);
      pix_item.last          = ~line_emit;

      end_item               = '0;
      end_item.kind          = KIND_LINE_END;
      end_item.line          = line_count_ff;
      end_item.copy_previous = line_dirty_ff & (line_count_ff != '0);
      end_item.frame_done    = line_inc >= lines_per_frame_ff;
      end_item.last          = 1'b1;
   end

   // pixel write goes out ahead of the line end
   always_comb begin
      push.v0    = step & (pix_emit | line_emit);
      push.v1    = step & pix_emit & line_emit;
      push.item0 = pix_emit ? pix_item : end_item;
      push.item1 = end_item;
   end

endmodule

### hdl/lcdsc_rsp_queue.sv
// small result queue taking up to two results per cycle, one out per cycle while out_ready is high
`timescale 1ns / 1ps

module lcdsc_rsp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  lcdsc_pkg::rsp_push_type  push,
   output logic                     room_two,
   output logic                     out_valid,
   input  logic                     out_ready,
   output lcdsc_pkg::rsp_item_type  out_item
);
   import lcdsc_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_item_type     entry_ff [RSP_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] tail_next;

   assign pop       = out_valid & out_ready;
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[head_ff];
   assign tail_next = tail_ff + 1'b1;
   // two free slots once the head transfer this cycle is counted
   assign room_two  = (CNT_W'(RSP_DEPTH) - count_ff + CNT_W'(pop)) >= CNT_W'(2);

   // pointer and fill bookkeeping
   always_comb begin
      head_in  = head_ff + PTR_W'(pop);
      tail_in  = tail_ff + PTR_W'(push.v0) + PTR_W'(push.v1);
      count_in = count_ff + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // entry writes
   always_ff @(posedge clock) begin
      if (push.v0) entry_ff[tail_ff]   <= push.item0;
      if (push.v1) entry_ff[tail_next] <= push.item1;
   end

endmodule

### hdl/lcd_scan_capture_decoder.sv
// top level of the lcd scan capture decoder
`timescale 1ns / 1ps

// Decodes oversampled GPIO words from a parallel LCD bus into pixel writes and
// line ends. Each accepted sample is held in an input register and decoded
// from there once the queue has room; its zero, one or two results land in a
// four-entry result queue that feeds the rsp stream. The block takes one
// sample per clock as long as the queue has room for two results, and a sample
// that ends a line right after a pixel edge yields two results. Config
// registers are written through the csr port; the user must write them only
// while the stream is idle, which the block itself does not enforce; index 0
// active_start, 1 active_end, 2 lines_per_frame, other indexes are ignored.

module lcd_scan_capture_decoder #(
   parameter int PIXEL_LIMIT = lcdsc_pkg::PIXEL_LIMIT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // config write port
   input  logic                                  csr_we,
   input  logic [lcdsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lcdsc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // sample stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [lcdsc_pkg::REQ_DATA_W-1:0]      req_tdata,  // sample
   input  logic [lcdsc_pkg::REQ_USER_W-1:0]      req_tuser,  // block_break, frame_start
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // line, column, color, copy_previous, frame_done, zero fill
   output logic [lcdsc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tuser,  // kind
   output logic                                  rsp_tlast
);
   import lcdsc_pkg::*;

   logic                in_valid_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic                in_break_ff;
   logic                in_frame_ff;
   logic                room_two;
   logic                step;
   rsp_push_type        push;
   rsp_item_type        head;

   // input register advances when the queue can take a full result pair
   assign step       = in_valid_ff & room_two;
   assign req_tready = ~in_valid_ff | room_two;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_sample_ff <= req_tdata;
         in_break_ff  <= req_tuser[0];
         in_frame_ff  <= req_tuser[1];
      end
   end

   lcdsc_core #(
      .PIXEL_LIMIT (PIXEL_LIMIT)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .step        (step),
      .sample      (in_sample_ff),
      .block_break (in_break_ff),
      .frame_start (in_frame_ff),
      .push        (push)
   );

   lcdsc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room_two  (room_two),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   // pack the head result onto the stream
   assign rsp_tdata = {3'b000, head.frame_done, head.copy_previous,
                       head.color, head.column, head.line};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
